// ===== rtl/hcs_pkg.sv =====
`default_nettype none
package hcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEADING     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OUTPUT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 3'd5;

  // register values after reset
  localparam logic [11:0] RST_BASE_HEADING     = 12'd0;
  localparam logic [10:0] RST_DEADBAND         = 11'd100;
  localparam logic [19:0] RST_GAIN             = 20'd171799;
  localparam logic [15:0] RST_MAX_CORRECTION   = 16'd983;
  localparam logic [15:0] RST_MIN_OUTPUT       = 16'd3277;
  localparam logic [15:0] RST_SMOOTHING_FACTOR = 16'd2621;

  // heading wrap limits, tenths of a degree
  localparam logic signed [12:0] WRAP_HALF = 13'sd1800;
  localparam logic signed [12:0] WRAP_FULL = 13'sd3600;

  // full scale drive, q15
  localparam logic [16:0] Q15_ONE = 17'd32768;

  typedef struct packed {
    logic [11:0] measured_heading;
    logic [15:0] base_left;
    logic [15:0] base_right;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        drive_left;
    logic [15:0]        drive_right;
    logic signed [11:0] hdg_err;
    logic               in_deadband;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_TGT,
    ST_SML,
    ST_SMR,
    ST_UPR,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MUL_CORR,
    MUL_LEFT,
    MUL_RIGHT
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     tgt_en;
    logic     upd_left;
    logic     upd_right;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic in_db;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/hcs_in_if.sv =====
`default_nettype none
interface hcs_in_if;
  import hcs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hcs_out_if.sv =====
`default_nettype none
interface hcs_out_if;
  import hcs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/heading_correction_smoother.sv =====
// Heading correction smoother
//
// Input channel in_ch carries one word per control update: the measured
// compass heading (tenths of a degree) and the base left and right drives
// (q15). Output channel out_ch returns one word per input word: the
// corrected drives, the wrapped heading error and a deadband flag.
// Configuration registers are written through cfg_we / cfg_index /
// cfg_wdata, by the user only while no word is in flight, which the block
// does not enforce; unknown indexes are ignored.
//
// One word is processed at a time. A word inside the deadband goes from
// acceptance straight to the result load; the single 17x21 multiplier
// is used in turn for a corrected word's correction and its left and
// right smoothing products. The next word is accepted the cycle after the
// result is loaded. A result held by a stalled receiver does not block
// acceptance of the next word; processing waits only if that word
// finishes first. Reset restores the register defaults and clears the
// smoothing state so the first correction seeds it again.
`default_nettype none
module heading_correction_smoother (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  hcs_in_if.sink                              in_ch,
  hcs_out_if.source                           out_ch
);
  import hcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  hcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hcs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_ch.data)
  );

endmodule
`default_nettype wire

// ===== rtl/hcs_ctrl.sv =====
`default_nettype none
module hcs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire hcs_pkg::status_t status,
  output hcs_pkg::cmd_t        cmd
);
  import hcs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_CORR;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CORR;
        end
      end
      ST_CORR: begin
        if (status.in_db) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_CORR;
          state_nxt   = ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.tgt_en = 1'b1;
        state_nxt  = ST_SML;
      end
      ST_SML: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LEFT;
        state_nxt   = ST_SMR;
      end
      ST_SMR: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_RIGHT;
        cmd.upd_left = 1'b1;
        state_nxt    = ST_UPR;
      end
      ST_UPR: begin
        cmd.upd_right = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_CORR))
    else $error("accepted word did not start processing");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise output valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

  a_one_smooth_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_left |=> (cmd.upd_right && !cmd.upd_left))
    else $error("smoothing update sequence broken");

endmodule
`default_nettype wire

// ===== rtl/hcs_datapath.sv =====
`default_nettype none
module hcs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire hcs_pkg::in_item_t              in_data,
  input  wire hcs_pkg::cmd_t                  cmd,
  output hcs_pkg::status_t                    status,
  output hcs_pkg::out_item_t                  out_data
);
  import hcs_pkg::*;

  // configuration registers
  logic [11:0] base_heading_r;
  logic [10:0] deadband_r;
  logic [19:0] gain_r;
  logic [15:0] max_corr_r;
  logic [15:0] min_out_r;
  logic [15:0] smooth_fac_r;

  // item registers
  logic [15:0]        bl_r, br_r;
  logic signed [11:0] err_r, err_nxt;
  logic signed [37:0] prod_r, prod_nxt;
  logic [15:0]        tl_r, tr_r, tl_nxt, tr_nxt;

  // smoothing state
  logic [15:0] sl_r, sr_r, sl_nxt, sr_nxt;
  logic        started_r;

  out_item_t out_r;

  logic signed [12:0] diff_h;
  logic [11:0]        mag;
  logic signed [16:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [21:0] corr_raw, corr, maxc;

  // smoothing step, saturated to the 16 bit range
  function automatic logic [15:0] smooth_step(input logic [15:0] cur,
                                              input logic signed [37:0] p);
    logic signed [23:0] s;
    begin
      s = $signed({8'b0, cur}) + 24'($signed(p[37:15]));
      if (s < 24'sd0) begin
        smooth_step = 16'd0;
      end else if (s > 24'sd65535) begin
        smooth_step = 16'hFFFF;
      end else begin
        smooth_step = s[15:0];
      end
    end
  endfunction

  // target drive, clamped to full scale and then to the minimum
  function automatic logic [15:0] target(input logic signed [21:0] t,
                                         input logic [15:0] lo);
    logic signed [21:0] v;
    begin
      v = t;
      if (v > $signed({5'b0, Q15_ONE})) begin
        v = $signed({5'b0, Q15_ONE});
      end
      if (v < $signed({6'b0, lo})) begin
        v = $signed({6'b0, lo});
      end
      target = v[15:0];
    end
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_heading_r <= RST_BASE_HEADING;
      deadband_r     <= RST_DEADBAND;
      gain_r         <= RST_GAIN;
      max_corr_r     <= RST_MAX_CORRECTION;
      min_out_r      <= RST_MIN_OUTPUT;
      smooth_fac_r   <= RST_SMOOTHING_FACTOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_HEADING:     base_heading_r <= cfg_wdata[11:0];
        REG_DEADBAND:         deadband_r     <= cfg_wdata[10:0];
        REG_GAIN:             gain_r         <= cfg_wdata[19:0];
        REG_MAX_CORRECTION:   max_corr_r     <= cfg_wdata[15:0];
        REG_MIN_OUTPUT:       min_out_r      <= cfg_wdata[15:0];
        REG_SMOOTHING_FACTOR: smooth_fac_r   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // heading error wrapped to one half turn either way
  always_comb begin
    diff_h = $signed({1'b0, in_data.measured_heading}) - $signed({1'b0, base_heading_r});
    if (diff_h > WRAP_HALF) begin
      diff_h = diff_h - WRAP_FULL;
    end else if (diff_h < -WRAP_HALF) begin
      diff_h = diff_h + WRAP_FULL;
    end
    err_nxt = diff_h[11:0];
  end

  // deadband test
  assign mag          = err_r[11] ? 12'(-err_r) : 12'(err_r);
  assign status.in_db = (mag < {1'b0, deadband_r});

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_CORR: begin
        mul_a = 17'(err_r);
        mul_b = $signed({1'b0, gain_r});
      end
      MUL_LEFT: begin
        mul_a = $signed({1'b0, tl_r}) - $signed({1'b0, sl_r});
        mul_b = $signed({5'b0, smooth_fac_r});
      end
      MUL_RIGHT: begin
        mul_a = $signed({1'b0, tr_r}) - $signed({1'b0, sr_r});
        mul_b = $signed({5'b0, smooth_fac_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // correction, floor of the product over 65536, clamped
  always_comb begin
    corr_raw = prod_r[37:16];
    maxc     = $signed({6'b0, max_corr_r});
    if (corr_raw > maxc) begin
      corr = maxc;
    end else if (corr_raw < -maxc) begin
      corr = -maxc;
    end else begin
      corr = corr_raw;
    end
    tl_nxt = target($signed({6'b0, bl_r}) - corr, min_out_r);
    tr_nxt = target($signed({6'b0, br_r}) + corr, min_out_r);
  end

  // smoothing state next values
  always_comb begin
    sl_nxt = sl_r;
    sr_nxt = sr_r;
    if (cmd.tgt_en && !started_r) begin
      sl_nxt = tl_nxt;
      sr_nxt = tr_nxt;
    end
    if (cmd.upd_left) begin
      sl_nxt = smooth_step(sl_r, prod_r);
    end
    if (cmd.upd_right) begin
      sr_nxt = smooth_step(sr_r, prod_r);
    end
  end

  // smoothing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r      <= '0;
      sr_r      <= '0;
      started_r <= 1'b0;
    end else begin
      sl_r <= sl_nxt;
      sr_r <= sr_nxt;
      if (cmd.tgt_en) begin
        started_r <= 1'b1;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bl_r  <= in_data.base_left;
      br_r  <= in_data.base_right;
      err_r <= err_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.tgt_en) begin
      tl_r <= tl_nxt;
      tr_r <= tr_nxt;
    end
    if (cmd.load_out) begin
      out_r.drive_left  <= status.in_db ? bl_r : sl_r;
      out_r.drive_right <= status.in_db ? br_r : sr_r;
      out_r.hdg_err     <= err_r;
      out_r.in_deadband <= status.in_db;
    end
  end

  assign out_data = out_r;

  // checks
  a_err_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (err_r <= 12'sd1800 && err_r >= -12'sd1800))
    else $error("heading error outside half turn");

  a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("smoothing seed flag cleared");

  a_seed_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tgt_en && !started_r) |=> (sl_r == tl_r && sr_r == tr_r))
    else $error("smoothing not seeded with targets");

endmodule
`default_nettype wire
